// ===== design/lldpv_pkg.sv =====
// shared types, codes and widths of the lldp frame validator
package lldpv_pkg;

	localparam int unsigned SKIP_W  = 6;
	localparam int unsigned LEN_W   = 9;
	localparam int unsigned TYPE_W  = 7;
	localparam int unsigned CNT_W   = 8;
	localparam int unsigned ERR_W   = 3;
	localparam int unsigned REQ_W   = 2;
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 6;

	localparam logic [SKIP_W-1:0] HEADER_SKIP_RESET = 6'd14;
	localparam logic [REQ_W-1:0]  REQ_DONE = 2'd3;
	localparam logic [CNT_W-1:0]  CNT_MAX  = 8'd255;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_HEADER_SKIP = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STRICT_END  = 1'd1;

	// verdict codes
	localparam logic [ERR_W-1:0] ERR_OK            = 3'd0;
	localparam logic [ERR_W-1:0] ERR_SHORT         = 3'd1;
	localparam logic [ERR_W-1:0] ERR_PAST_END      = 3'd2;
	localparam logic [ERR_W-1:0] ERR_END_MISPLACED = 3'd3;
	localparam logic [ERR_W-1:0] ERR_ORDER         = 3'd4;
	localparam logic [ERR_W-1:0] ERR_NO_END        = 3'd5;
	localparam logic [ERR_W-1:0] ERR_TOO_FEW       = 3'd6;

	typedef enum logic [5:0] {
		PH_SKIP      = 6'b000001,
		PH_HDR0      = 6'b000010,
		PH_HDR1      = 6'b000100,
		PH_VALUE     = 6'b001000,
		PH_AFTER_END = 6'b010000,
		PH_FAILED    = 6'b100000
	} phase_t;

	typedef struct packed {
		logic [SKIP_W-1:0] header_skip;
		logic              strict_end;
	} cfg_t;

	typedef struct packed {
		logic              packet_valid;
		logic [ERR_W-1:0]  error_code;
		logic [CNT_W-1:0]  tlv_count;
	} result_t;

endpackage

// ===== design/lldpv_tlv_fsm.sv =====
// per-frame tlv walker: state registers, next-state logic and verdict
module lldpv_tlv_fsm (
	input  logic                      clk,
	input  logic                      arst_n,
	input  lldpv_pkg::cfg_t           cfg,
	input  logic                      step,
	input  logic [7:0]                data,
	input  logic                      last,
	output lldpv_pkg::result_t        result
);
	import lldpv_pkg::*;

	phase_t            phase_q,   phase_d;
	logic [SKIP_W-1:0] skip_q,    skip_d;
	logic [LEN_W-1:0]  remain_q,  remain_d;
	logic              len_hi_q,  len_hi_d;
	logic [REQ_W-1:0]  req_q,     req_d;
	logic              end_q,     end_d;
	logic [ERR_W-1:0]  err_q,     err_d;
	logic              pend_q,    pend_d;
	logic [CNT_W-1:0]  cnt_q,     cnt_d;

	// byte processing and verdict on the updated state
	always_comb begin
		phase_t           work;
		logic [TYPE_W-1:0] tlv_type;
		logic              complete;
		logic [ERR_W-1:0]  code;
		phase_d  = phase_q;
		skip_d   = skip_q;
		remain_d = remain_q;
		len_hi_d = len_hi_q;
		req_d    = req_q;
		end_d    = end_q;
		err_d    = err_q;
		pend_d   = pend_q;
		cnt_d    = cnt_q;
		tlv_type = data[7:1];
		complete = 1'b0;
		work     = phase_q;
		code     = ERR_OK;

		// header skip: count the skipped bytes; once finished, this byte starts the first tlv
		if (phase_q == PH_SKIP) begin
			if (skip_q < cfg.header_skip) begin
				skip_d = SKIP_W'(skip_q + SKIP_W'(1));
			end else begin
				work = PH_HDR0;
			end
		end

		case (work)
			PH_HDR0: begin
				len_hi_d = data[0];
				if (tlv_type == '0) begin
					end_d = 1'b1;
				end else if (req_q < REQ_DONE) begin
					if (tlv_type != TYPE_W'(req_q) + TYPE_W'(1))
						pend_d = 1'b1;
					req_d = REQ_W'(req_q + REQ_W'(1));
				end
				phase_d = PH_HDR1;
			end
			PH_HDR1: begin
				remain_d = {len_hi_q, data};
				if (cnt_q != CNT_MAX)
					cnt_d = CNT_W'(cnt_q + CNT_W'(1));
				if (remain_d != '0)
					phase_d = PH_VALUE;
				else if (end_q)
					phase_d = PH_AFTER_END;
				else
					complete = 1'b1;
			end
			PH_VALUE: begin
				remain_d = LEN_W'(remain_q - LEN_W'(1));
				if (remain_d == '0)
					complete = 1'b1;
			end
			PH_AFTER_END: begin
				err_d   = ERR_END_MISPLACED;
				phase_d = PH_FAILED;
			end
			default: begin
			end
		endcase

		// whole tlv received
		if (complete) begin
			if (end_d) begin
				err_d   = ERR_END_MISPLACED;
				phase_d = PH_FAILED;
			end else if (pend_d) begin
				err_d   = ERR_ORDER;
				phase_d = PH_FAILED;
			end else begin
				phase_d = PH_HDR0;
			end
		end

		// verdict from the state after this byte
		if (err_d != ERR_OK) begin
			code = err_d;
		end else begin
			case (phase_d)
				PH_SKIP:  code = ERR_SHORT;
				PH_HDR1:  code = (cnt_d == '0) ? ERR_SHORT : ERR_PAST_END;
				PH_VALUE: code = ERR_PAST_END;
				PH_HDR0:  code = (cnt_d == '0) ? ERR_SHORT : ERR_OK;
				default:  code = ERR_OK;
			endcase
			if (code == ERR_OK) begin
				if (req_d < REQ_DONE)
					code = ERR_TOO_FEW;
				else if (!end_d && cfg.strict_end)
					code = ERR_NO_END;
			end
		end
		result.packet_valid = (code == ERR_OK);
		result.error_code   = code;
		result.tlv_count    = cnt_d;
	end

	// state registers, cleared at the end of every frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SKIP;
			skip_q   <= '0;
			remain_q <= '0;
			len_hi_q <= 1'b0;
			req_q    <= '0;
			end_q    <= 1'b0;
			err_q    <= ERR_OK;
			pend_q   <= 1'b0;
			cnt_q    <= '0;
		end else if (step) begin
			if (last) begin
				phase_q  <= PH_SKIP;
				skip_q   <= '0;
				remain_q <= '0;
				len_hi_q <= 1'b0;
				req_q    <= '0;
				end_q    <= 1'b0;
				err_q    <= ERR_OK;
				pend_q   <= 1'b0;
				cnt_q    <= '0;
			end else begin
				phase_q  <= phase_d;
				skip_q   <= skip_d;
				remain_q <= remain_d;
				len_hi_q <= len_hi_d;
				req_q    <= req_d;
				end_q    <= end_d;
				err_q    <= err_d;
				pend_q   <= pend_d;
				cnt_q    <= cnt_d;
			end
		end
	end

endmodule

// ===== design/lldp_packet_validator_core.sv =====
// top level of the lldp frame validator: input stage, tlv walker, verdict register
//
// usage
// - input channel: one frame byte per item (data_byte, last_byte) on
//   in_valid/in_ready; last_byte marks the final byte of a frame
// - output channel: one verdict per frame (packet_valid, error_code,
//   tlv_count) on out_valid/out_ready, given when the last byte is processed
// - config: cfg_we writes cfg_data to register cfg_index (0 header_skip,
//   1 strict_end); write only while no frame is in flight
// - throughput: one byte per cycle unless a last byte waits on a full verdict slot,
//   set by the combinational tlv walker between the input and verdict registers
// - verdict path: an accepted last byte passes the input register and then the
//   verdict register; a full verdict slot can hold it in the input stage
// - stall: while a verdict waits on out_ready, bytes that do not end a
//   frame keep flowing; a second last byte holds in the input stage
// - reset: header_skip returns to 14, strict_end to 0, all frame state
//   clears and both channels go empty
module lldp_packet_validator_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [7:0]                        data_byte,
	input  logic                              last_byte,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              packet_valid,
	output logic [lldpv_pkg::ERR_W-1:0]       error_code,
	output logic [lldpv_pkg::CNT_W-1:0]       tlv_count,
	input  logic                              cfg_we,
	input  logic [lldpv_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lldpv_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import lldpv_pkg::*;

	cfg_t       cfg_q;
	logic       valid_s1;
	logic [7:0] data_s1;
	logic       last_s1;
	logic       adv;
	result_t    result;
	result_t    res_q;
	logic       out_valid_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_skip <= HEADER_SKIP_RESET;
			cfg_q.strict_end  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HEADER_SKIP: cfg_q.header_skip <= cfg_data;
				REG_STRICT_END:  cfg_q.strict_end  <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// the stage item moves on unless it ends a frame and the verdict slot is full
	assign adv      = valid_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	lldpv_tlv_fsm u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.step   (adv),
		.data   (data_s1),
		.last   (last_s1),
		.result (result)
	);

	// verdict register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1)
			res_q <= result;
	end

	assign out_valid    = out_valid_q;
	assign packet_valid = res_q.packet_valid;
	assign error_code   = res_q.error_code;
	assign tlv_count    = res_q.tlv_count;

`ifndef SYNTHESIS
	// an empty verdict slot never blocks the input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ready)
		else $error("input stalled with empty verdict slot");

	// the valid flag agrees with the code
	a_valid_matches_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (packet_valid == (error_code == ERR_OK)))
		else $error("packet_valid disagrees with error_code");

	// a verdict is only produced when a last byte leaves the input stage
	a_verdict_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(adv && last_s1))
		else $error("verdict without a last byte");
`endif

endmodule
